FILE: hw/rtl/cmlp_pkg.sv
// Shared types, codes and character constants for the code map line parser.
`default_nettype none
package cmlp_pkg;

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_EOL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REL_START = 3'd0,
    REL_SIGN  = 3'd1,
    REL_ZERO  = 3'd2,
    REL_X     = 3'd3,
    REL_DIG   = 3'd4
  } rel_t;

  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOKEN     = 3'd1;
  localparam logic [2:0] ERR_OFFSET    = 3'd2;
  localparam logic [2:0] ERR_VALUE     = 3'd3;
  localparam logic [2:0] ERR_RANGE_CH  = 3'd4;
  localparam logic [2:0] ERR_RANGE     = 3'd5;
  localparam logic [2:0] ERR_DUPLICATE = 3'd6;

  localparam logic [16:0] VAL_SAT    = 17'h10000;
  localparam logic [16:0] MAX_CODE   = 17'h0FFFF;
  localparam logic [16:0] MAX_OFFSET = 17'h000FF;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D7    = 8'h37;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic rng_rd;
    logic rng_step;
    logic clr_step;
    logic init_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic sel_ok;
    logic rng_go;
    logic dup;
    logic rng_last;
    logic tclr_last;
    logic init_last;
  } stat_t;

  // Digit value of a character, 16 when it is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cmlp_ctrl.sv
// Controller state machine of the code map line parser.
`default_nettype none
module cmlp_ctrl
  import cmlp_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  wire   out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Sequence one request through its phases
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == OP_CLEAR) state_next = stat.sel_ok ? S_CLR : S_OUT;
        else if (stat.rng_go) state_next = S_RD;
        else state_next = S_OUT;
      end
      S_RD: begin
        cmd.rng_rd = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.rng_step = 1'b1;
        state_next = (stat.dup || stat.rng_last) ? S_OUT : S_RD;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.tclr_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cmlp_dp.sv
// Datapath of the code map line parser: parse registers, table memory, result register.
`default_nettype none
module cmlp_dp
  import cmlp_pkg::*;
#(
  parameter int NUM_TABLES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire  [1:0]  op,
  input  wire  [3:0]  table_sel,
  input  wire  [7:0]  char_byte,
  input  wire  [7:0]  slot,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [2:0]  status,
  output logic        line_done,
  output logic [15:0] code
);

  localparam int TBL_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW    = TBL_W + 8;
  localparam int DEPTH = NUM_TABLES * 256;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [8:0]    NT        = 9'(NUM_TABLES);

  // Held request
  op_t        it_op;
  logic [3:0] it_sel;
  logic [7:0] it_char;
  logic [7:0] it_slot;

  // Parser state
  logic        p_second;
  rel_t        p_rel;
  base_t       p_base;
  logic        p_neg;
  logic [16:0] fv, sv;
  logic [8:0]  cursor;
  logic [2:0]  err;

  // Range and sweep state
  logic [15:0]   rng_code;
  logic [7:0]    rng_left;
  logic [AW-1:0] clr_addr;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;

  logic [7:0]    sel8;
  logic [TBL_W-1:0] tsel;
  logic          sel_ok;
  logic          dup;

  // Next parser values
  logic        n_second, n_neg, rng_go;
  rel_t        n_rel;
  base_t       n_base;
  logic [16:0] n_fv, n_sv, acc, acc_n, vf, v1, v2, diff, span;
  logic [8:0]  n_cursor;
  logic [2:0]  n_err;
  logic [7:0]  ch;
  logic        eol, sep, consumed, done_num, active;
  logic [4:0]  hv, radix;
  logic [20:0] a21, prod, dsum;
  logic [16:0] acc_sat;

  assign sel8   = {4'b0, it_sel};
  assign tsel   = sel8[TBL_W-1:0];
  assign sel_ok = {1'b0, sel8} < NT;
  assign dup    = sel_ok && (rdata != 16'd0);

  assign stat.op        = it_op;
  assign stat.sel_ok    = sel_ok;
  assign stat.rng_go    = rng_go;
  assign stat.dup       = dup;
  assign stat.rng_last  = (rng_left == 8'd0);
  assign stat.tclr_last = (clr_addr[7:0] == 8'hFF);
  assign stat.init_last = (clr_addr == LAST_ADDR);

  // Digit accumulate with saturation
  always_comb begin
    acc   = p_second ? sv : fv;
    hv    = hex_val(ch);
    radix = (p_base == BASE_OCT) ? 5'd8 : ((p_base == BASE_HEX) ? 5'd16 : 5'd10);
    a21   = {4'b0, acc};
    case (p_base)
      BASE_OCT: prod = a21 << 3;
      BASE_HEX: prod = a21 << 4;
      default:  prod = (a21 << 3) + (a21 << 1);
    endcase
    dsum    = prod + {17'b0, hv[3:0]};
    acc_sat = (dsum > {4'b0, VAL_SAT}) ? VAL_SAT : dsum[16:0];
    vf      = (p_neg && acc != 17'd0) ? VAL_SAT : acc;
  end

  // Advance the parser by one character or end of line
  always_comb begin
    eol      = (it_op == OP_EOL);
    ch       = eol ? CH_SPACE : it_char;
    sep      = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D) || (ch == 8'h00);
    active   = (err == ERR_NONE) &&
               ((it_op == OP_CHAR) || (eol && (p_second || p_rel != REL_START)));
    n_second = p_second;
    n_rel    = p_rel;
    n_base   = p_base;
    n_neg    = p_neg;
    n_fv     = fv;
    n_sv     = sv;
    n_cursor = cursor;
    n_err    = err;
    rng_go   = 1'b0;
    consumed = 1'b0;
    acc_n    = acc;
    done_num = (p_rel == REL_ZERO) || (p_rel == REL_DIG);
    v1       = 17'd0;
    v2       = 17'd0;
    diff     = 17'd0;
    span     = 17'd0;
    if (active && !(p_rel == REL_START && sep && !eol)) begin
      if (!eol) begin
        if (p_rel == REL_START && (ch == CH_PLUS || ch == CH_MINUS)) begin
          n_neg = (ch == CH_MINUS); n_rel = REL_SIGN; consumed = 1'b1;
        end else if ((p_rel == REL_START || p_rel == REL_SIGN) && ch == CH_D0) begin
          acc_n = 17'd0; n_rel = REL_ZERO; consumed = 1'b1;
        end else if ((p_rel == REL_START || p_rel == REL_SIGN) &&
                     ch >= CH_D1 && ch <= CH_D9) begin
          acc_n = {13'b0, hv[3:0]}; n_base = BASE_DEC; n_rel = REL_DIG; consumed = 1'b1;
        end else if (p_rel == REL_ZERO && (ch == CH_LX || ch == CH_UX)) begin
          n_rel = REL_X; consumed = 1'b1;
        end else if (p_rel == REL_ZERO && ch >= CH_D0 && ch <= CH_D7) begin
          acc_n = {13'b0, hv[3:0]}; n_base = BASE_OCT; n_rel = REL_DIG; consumed = 1'b1;
        end else if (p_rel == REL_X && hv < 5'd16) begin
          acc_n = {13'b0, hv[3:0]}; n_base = BASE_HEX; n_rel = REL_DIG; consumed = 1'b1;
        end else if (p_rel == REL_DIG && hv < radix) begin
          acc_n = acc_sat; consumed = 1'b1;
        end
      end
      if (consumed) begin
        if (p_second) n_sv = acc_n;
        else n_fv = acc_n;
      end else begin
        // Token ends here: drop back between tokens unless a range continues
        n_second = 1'b0;
        n_rel    = REL_START;
        n_base   = BASE_NONE;
        n_neg    = 1'b0;
        if (!p_second) begin
          if (!done_num) n_err = ERR_TOKEN;
          else if (!eol && ch == CH_COLON) begin
            if (vf > MAX_OFFSET) n_err = ERR_OFFSET;
            else n_cursor = vf[8:0];
          end else if (!eol && ch == CH_UNDER) begin
            if (vf > MAX_CODE) n_err = ERR_VALUE;
            else begin
              n_fv = vf; n_sv = 17'd0; n_second = 1'b1;
            end
          end else if (eol || sep) begin
            v1 = vf; v2 = vf;
          end else n_err = ERR_TOKEN;
        end else begin
          if (!done_num) n_err = ERR_RANGE_CH;
          else if (eol || sep) begin
            v1 = fv; v2 = vf;
          end else n_err = (vf > MAX_CODE) ? ERR_VALUE : ERR_RANGE_CH;
        end
        // Check a range or single value before it is written
        if (done_num && (eol || sep)) begin
          diff = v2 - v1;
          span = {8'b0, cursor} + diff;
          if (v1 > MAX_CODE || v2 > MAX_CODE) n_err = ERR_VALUE;
          else if (v2 < v1 || span > MAX_OFFSET) n_err = ERR_RANGE;
          else rng_go = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_second <= 1'b0;
      p_rel    <= REL_START;
      p_base   <= BASE_NONE;
      p_neg    <= 1'b0;
      fv       <= 17'd0;
      sv       <= 17'd0;
      cursor   <= 9'd0;
      err      <= ERR_NONE;
      clr_addr <= '0;
    end else begin
      if (cmd.exec) begin
        if (it_op == OP_CHAR || it_op == OP_EOL) begin
          p_second <= n_second;
          p_rel    <= n_rel;
          p_base   <= n_base;
          p_neg    <= n_neg;
          fv       <= n_fv;
          sv       <= n_sv;
          cursor   <= n_cursor;
          err      <= n_err;
        end else if (it_op == OP_CLEAR) begin
          p_second <= 1'b0;
          p_rel    <= REL_START;
          p_base   <= BASE_NONE;
          p_neg    <= 1'b0;
          fv       <= 17'd0;
          sv       <= 17'd0;
          cursor   <= 9'd0;
          err      <= ERR_NONE;
          clr_addr <= {tsel, 8'h00};
        end
      end
      if (cmd.rng_step) begin
        if (dup) err <= ERR_DUPLICATE;
        else cursor <= cursor + 9'd1;
      end
      if (cmd.init_step || cmd.clr_step) clr_addr <= clr_addr + AW'(1);
      // End of line leaves the parser between tokens at slot 0
      if (cmd.load_out && it_op == OP_EOL) begin
        p_second <= 1'b0;
        p_rel    <= REL_START;
        p_base   <= BASE_NONE;
        p_neg    <= 1'b0;
        fv       <= 17'd0;
        sv       <= 17'd0;
        cursor   <= 9'd0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_op   <= op_t'(op);
      it_sel  <= table_sel;
      it_char <= char_byte;
      it_slot <= slot;
    end
    if (cmd.exec && rng_go) begin
      rng_code <= v1[15:0];
      rng_left <= diff[7:0];
    end
    if (cmd.rng_step && !dup) begin
      rng_code <= rng_code + 16'd1;
      rng_left <= rng_left - 8'd1;
    end
    if (cmd.load_out) begin
      status    <= err;
      line_done <= (it_op == OP_EOL);
      code      <= (it_op == OP_LOOKUP && sel_ok) ? rdata : 16'd0;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.init_step || cmd.clr_step) mem[clr_addr] <= 16'd0;
    else if (cmd.rng_step && sel_ok && !dup) mem[{tsel, cursor[7:0]}] <= rng_code;
    if (cmd.exec) rdata <= mem[{tsel, it_slot}];
    else if (cmd.rng_rd) rdata <= mem[{tsel, cursor[7:0]}];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/code_map_line_parser.sv
// Top level of the code map line parser: controller plus datapath.
// A character, end of line or lookup passes through the EXEC and OUT states to the result register;
// a new request is taken only once that result is loaded. A range write adds, per slot, a read
// for the duplicate check, then a write. A table clear zeroes 256 slots, one slot per cycle
// through the single write port. After reset a clearing pass zeroes all NUM_TABLES*256 entries;
// no request is taken during it. The next request is accepted while a result waits.
`default_nettype none
module code_map_line_parser
  import cmlp_pkg::*;
#(
  parameter int NUM_TABLES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  op,
  input  wire  [3:0]  table_sel,
  input  wire  [7:0]  char_byte,
  input  wire  [7:0]  slot,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic        line_done,
  output logic [15:0] code
);

  cmd_t  cmd;
  stat_t stat;

  cmlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmlp_dp #(
    .NUM_TABLES (NUM_TABLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .table_sel (table_sel),
    .char_byte (char_byte),
    .slot      (slot),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .line_done (line_done),
    .code      (code)
  );

endmodule
`default_nettype wire
